/* hw/rtl/wbps_pkg.sv */
package wbps_pkg;

    // Fixed field widths.
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 32;
    localparam int LEN_W      = 5;
    localparam int PAT_BYTES  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD_MASK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd3;

    // Pattern setup as seen by the compare logic.
    typedef struct packed {
        logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
        logic [PAT_BYTES-1:0]             mask;
        logic [LEN_W-1:0]                 len;    // clamped to 1..MAX_PATTERN
    } t_cfg;

endpackage

/* hw/rtl/wildcard_byte_pattern_search.sv */
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_data_byte, i_region_end
// result    out        o_out_valid / i_out_stall o_found, o_match_offset
// config    in         i_cfg_wr                  i_cfg_idx, i_cfg_data
//
// One byte is taken each cycle unless the input stalls; a byte is held in the input register and the
// window compare and count update run between it and the result register.
// A result is loaded into the result register when its byte leaves the input register.
// Reset is synchronous; it clears the scan state and sets the pattern length to one.
// The input stalls only when a request must go out while the result register is held.
module wildcard_byte_pattern_search
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_region_end,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_found,
    output logic [CNT_W-1:0]      o_match_offset,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;

    logic                               r_in_vld;
    logic [BYTE_W-1:0]                  r_in_byte;
    logic                               r_in_last;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] r_win;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] n_win;
    logic [CNT_W-1:0]                   r_count;
    logic [CNT_W-1:0]                   n_count;
    logic                               r_rep;
    logic                               r_out_vld;
    logic                               r_found;
    logic [CNT_W-1:0]                   r_offset;
    logic                               win_hit;
    logic                               hit;
    logic                               emit;
    logic                               adv;
    logic                               in_acc;

    wbps_cfg #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (i_cfg_wr),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Window after the held byte is shifted in.
    always_comb begin
        n_win[0] = r_in_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    // Byte count saturates at all ones.
    assign n_count = (r_count == '1) ? r_count : r_count + CNT_W'(1);

    wbps_match #(.MAX_PATTERN(MAX_PATTERN)) u_match (
        .i_cfg (cfg),
        .i_win (n_win),
        .o_hit (win_hit)
    );

    // A hit needs enough bytes in this region and no earlier report.
    assign hit  = !r_rep && (n_count >= CNT_W'(cfg.len)) && win_hit;
    assign emit = !r_rep && (hit || r_in_last);
    assign adv  = r_in_vld && (!emit || !r_out_vld || !i_out_stall);

    assign o_in_stall = r_in_vld && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_region_end;
        end
    end

    // Scan state; entries older than the count are never compared, so the window needs no clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rep   <= 1'b0;
        end else if (adv) begin
            if (r_in_last) begin
                r_count <= '0;
                r_rep   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_rep   <= r_rep || hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_win <= n_win;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_found  <= hit;
            r_offset <= hit ? (n_count - CNT_W'(cfg.len)) : '0;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_found        = r_found;
    assign o_match_offset = r_offset;

`ifndef ASSERT_OFF
    a_unfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_match_offset == '0)
        else $error("unmatched result carries a nonzero offset");

    a_rep_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep |-> r_count != '0)
        else $error("report flag set with an empty region");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> r_count == '0 && !r_rep)
        else $error("scan state not cleared after region end");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && emit |=> o_out_valid)
        else $error("result request lost");

    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && hit && !r_in_last |=> !hit)
        else $error("second match reported in one region");
`endif

endmodule

/* hw/rtl/wbps_cfg.sv */
module wbps_cfg
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_PATTERN);

    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [PAT_BYTES-1:0]  r_mask;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      n_len_used;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_mask   <= '0;
            r_len    <= LEN_W'(1);
        end else if (i_cfg_wr) begin
            case (i_cfg_idx)
                CFG_PATTERN_LOW:    r_pat_lo <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pat_hi <= i_cfg_data;
                CFG_WILDCARD_MASK:  r_mask   <= i_cfg_data[PAT_BYTES-1:0];
                CFG_PATTERN_LENGTH: r_len    <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // A length of zero counts as one; anything above the cap counts as the cap.
    always_comb begin
        if (r_len == '0) begin
            n_len_used = LEN_W'(1);
        end else if (r_len > LEN_CAP) begin
            n_len_used = LEN_CAP;
        end else begin
            n_len_used = r_len;
        end
    end

    assign o_cfg.pattern = {r_pat_hi, r_pat_lo};
    assign o_cfg.mask    = r_mask;
    assign o_cfg.len     = n_len_used;

endmodule

/* hw/rtl/wbps_match.sv */
module wbps_match
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  t_cfg                               i_cfg,
    input  logic [MAX_PATTERN-1:0][BYTE_W-1:0] i_win,
    output logic                               o_hit
);

    localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [LEN_W-1:0] n_idx [MAX_PATTERN];

    // Pattern byte k lines up with the window entry len-1-k; index 0 is the newest byte.
    always_comb begin
        o_hit = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            n_idx[k] = i_cfg.len - LEN_W'(1) - LEN_W'(k);
            if ((LEN_W'(k) < i_cfg.len) && !i_cfg.mask[k]) begin
                if (i_win[n_idx[k][WIN_IDX_W-1:0]] != i_cfg.pattern[k]) begin
                    o_hit = 1'b0;
                end
            end
        end
    end

endmodule
